// ===== src/sida_pkg.sv =====
package sida_pkg;

	localparam int VALUE_WIDTH_DEF = 16;
	localparam int CHAR_WIDTH      = 6;

	localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 6'd48;
	localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 6'd45;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SKIP,
		ST_SIGN,
		ST_DIGIT
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic skip;
		logic emit_sign;
		logic emit_digit;
	} cmd_t;

	typedef struct packed {
		logic conv_done;
		logic top_zero;
		logic one_left;
		logic negative;
		logic out_free;
	} status_t;

	// decimal digits needed for the largest unsigned value of w bits
	function automatic int num_digits(int w);
		longint unsigned v;
		int n;
		v = (64'd1 << w) - 64'd1;
		n = 0;
		for (int i = 0; i < 20; i++) begin
			if (v != 0) begin
				v = v / 10;
				n++;
			end
		end
		return n;
	endfunction

endpackage

// ===== src/sida_ctrl.sv =====
module sida_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  sida_pkg::status_t status,
	output sida_pkg::cmd_t    cmd
);

	sida_pkg::state_t state_q;
	sida_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sida_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			sida_pkg::ST_IDLE: begin
				if (in_valid) state_d = sida_pkg::ST_CONV;
			end
			sida_pkg::ST_CONV: begin
				if (status.conv_done) state_d = sida_pkg::ST_SKIP;
			end
			sida_pkg::ST_SKIP: begin
				if (!status.top_zero || status.one_left) begin
					state_d = status.negative ? sida_pkg::ST_SIGN : sida_pkg::ST_DIGIT;
				end
			end
			sida_pkg::ST_SIGN: begin
				if (status.out_free) state_d = sida_pkg::ST_DIGIT;
			end
			sida_pkg::ST_DIGIT: begin
				if (status.out_free && status.one_left) state_d = sida_pkg::ST_IDLE;
			end
			default: state_d = sida_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			sida_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			sida_pkg::ST_CONV:  cmd.step = 1'b1;
			sida_pkg::ST_SKIP:  cmd.skip = status.top_zero && !status.one_left;
			sida_pkg::ST_SIGN:  cmd.emit_sign = status.out_free;
			sida_pkg::ST_DIGIT: cmd.emit_digit = status.out_free;
			default: begin
				cmd      = '0;
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

// ===== src/sida_dp.sv =====
module sida_dp #(
	parameter int VALUE_WIDTH = sida_pkg::VALUE_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic signed [VALUE_WIDTH-1:0]     value,
	input  sida_pkg::cmd_t                    cmd,
	output sida_pkg::status_t                 status,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [sida_pkg::CHAR_WIDTH-1:0]   character,
	output logic                              last
);

	localparam int NumDigits = sida_pkg::num_digits(VALUE_WIDTH);
	localparam int BcdW      = 4 * NumDigits;
	localparam int BitCntW   = $clog2(VALUE_WIDTH);
	localparam int DigCntW   = $clog2(NumDigits + 1);

	logic [VALUE_WIDTH-1:0] mag_q;
	logic [BcdW-1:0]        bcd_q;
	logic [BcdW-1:0]        bcd_adj;
	logic [BitCntW-1:0]     bit_cnt_q;
	logic [DigCntW-1:0]     dig_cnt_q;
	logic                   neg_q;
	logic                   out_valid_q;
	logic [sida_pkg::CHAR_WIDTH-1:0] char_q;
	logic                   last_q;
	logic [3:0]             top_digit;

	assign top_digit = bcd_q[BcdW-1 -: 4];

	// add-3 correction on every BCD digit before the shift
	always_comb begin
		for (int i = 0; i < NumDigits; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			neg_q     <= value[VALUE_WIDTH-1];
			mag_q     <= value[VALUE_WIDTH-1] ? VALUE_WIDTH'(-value) : VALUE_WIDTH'(value);
			bcd_q     <= '0;
			bit_cnt_q <= BitCntW'(VALUE_WIDTH - 1);
			dig_cnt_q <= DigCntW'(NumDigits);
		end else if (cmd.step) begin
			{bcd_q, mag_q} <= {bcd_adj[BcdW-2:0], mag_q, 1'b0};
			bit_cnt_q      <= bit_cnt_q - 1'b1;
		end else if (cmd.skip || cmd.emit_digit) begin
			bcd_q     <= {bcd_q[BcdW-5:0], 4'd0};
			dig_cnt_q <= dig_cnt_q - 1'b1;
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_sign || cmd.emit_digit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_sign) begin
			char_q <= sida_pkg::CHAR_MINUS;
			last_q <= 1'b0;
		end else if (cmd.emit_digit) begin
			char_q <= sida_pkg::CHAR_ZERO + sida_pkg::CHAR_WIDTH'(top_digit);
			last_q <= (dig_cnt_q == DigCntW'(1));
		end
	end

	assign status.conv_done = (bit_cnt_q == '0);
	assign status.top_zero  = (top_digit == 4'd0);
	assign status.one_left  = (dig_cnt_q == DigCntW'(1));
	assign status.negative  = neg_q;
	assign status.out_free  = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign character = char_q;
	assign last      = last_q;

endmodule

// ===== src/signed_int_to_decimal_ascii_core.sv =====
// channel  | handshake            | payload
// ---------+----------------------+-------------------------------------------
// in       | in_valid / in_ready  | value [VALUE_WIDTH-1:0] signed
// out      | out_valid / out_ready| character [5:0], last (final word of text)
//
// One value at a time: the shift-and-add-3 conversion takes one magnitude bit per
// cycle, leading zero digits are then skipped, and the sign when negative and the
// digits follow at one character per cycle while the output is not stalled.
// A new value is taken while the last character still waits in the output register.
// Reset (arst_n low) returns to idle and drops any pending word.
// Output stalls hold the character sequencer; conversion itself never stalls.
module signed_int_to_decimal_ascii_core #(
	parameter int VALUE_WIDTH = sida_pkg::VALUE_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic signed [VALUE_WIDTH-1:0]   value,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [sida_pkg::CHAR_WIDTH-1:0] character,
	output logic                            last
);

	sida_pkg::cmd_t    cmd;
	sida_pkg::status_t status;

	sida_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	sida_dp #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.value     (value),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.character (character),
		.last      (last)
	);

endmodule

// ===== src/sida_chk.sv =====
module sida_chk (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [sida_pkg::CHAR_WIDTH-1:0] character,
	input logic                            last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(character) && $stable(last))
		else $error("output word changed while stalled");

	a_char_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> character == sida_pkg::CHAR_MINUS ||
			(character >= sida_pkg::CHAR_ZERO && character <= sida_pkg::CHAR_ZERO + 6'd9))
		else $error("illegal character");

	a_sign_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && character == sida_pkg::CHAR_MINUS |-> !last)
		else $error("sign flagged as final word");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second value taken during conversion");

endmodule

bind signed_int_to_decimal_ascii_core sida_chk u_sida_chk (.*);

// ===== tb/signed_int_to_decimal_ascii_core_tb.sv =====
module signed_int_to_decimal_ascii_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int VW         = sida_pkg::VALUE_WIDTH_DEF;
	localparam int CW         = sida_pkg::CHAR_WIDTH;
	localparam int STALL_MAX  = 2000;
	localparam int DRAIN_WAIT = VW + 14;

	typedef struct packed {
		logic [CW-1:0] character;
		logic          last;
	} char_word_t;

	typedef struct {
		logic signed [VW-1:0] value;
		string                text;
	} vector_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic signed [VW-1:0] value;
	logic                 out_valid;
	logic                 out_ready;
	logic [CW-1:0]        character;
	logic                 last;

	char_word_t pending_chars[$];
	int         errors = 0;
	int         send_idle;
	int         recv_idle;
	int         stall_cycles = 0;

	// empty text: expected characters come from decimal_text()
	vector_row_t vectors[] = '{
		'{16'sd0,      "0"},
		'{16'sd1,      "1"},
		'{-16'sd1,     "-1"},
		'{16'sd9,      "9"},
		'{16'sd10,     "10"},
		'{-16'sd10,    "-10"},
		'{16'sd99,     ""},
		'{16'sd100,    ""},
		'{-16'sd999,   ""},
		'{16'sd1000,   ""},
		'{16'sd9999,   ""},
		'{-16'sd10000, ""},
		'{16'sd32767,  "32767"},
		'{-16'sd32767, "-32767"},
		'{-16'sd32768, "-32768"},
		'{16'sd12345,  ""},
		'{16'h5555,    ""},
		'{16'hAAAA,    ""},
		'{16'h7FFE,    ""},
		'{16'h8001,    ""},
		'{-16'sd9,     ""},
		'{16'sd20480,  ""}
	};

	signed_int_to_decimal_ascii_core #(
		.VALUE_WIDTH(VW)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.value    (value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.character(character),
		.last     (last)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// expected text of one value, most significant character first
	function automatic void decimal_text(input logic [VW-1:0] v);
		logic          neg;
		logic [VW-1:0] mag;
		logic [CW-1:0] digs[$];
		neg = v[VW-1];
		mag = neg ? -v : v;   // unsigned, so the most negative value survives
		do begin
			digs.push_front(sida_pkg::CHAR_ZERO + CW'(mag % 10));
			mag = mag / 10;
		end while (mag != 0);
		if (neg)
			pending_chars.push_back('{sida_pkg::CHAR_MINUS, 1'b0});
		foreach (digs[i])
			pending_chars.push_back('{digs[i], i == digs.size() - 1});
	endfunction

	function automatic logic signed [VW-1:0] random_value();
		int bounds[8] = '{9, 10, 99, 100, 999, 1000, 9999, 10000};
		int v;
		case ($urandom_range(4))
			0, 1: v = $urandom;
			2: v = int'($urandom_range(18)) - 9;
			3: v = bounds[$urandom_range(7)] * ($urandom_range(1) ? -1 : 1);
			default: v = int'($urandom_range(1998)) - 999;
		endcase
		return VW'(v);
	endfunction

	// called at a rising edge; valid stays high across back-to-back words
	task automatic send_word(input logic signed [VW-1:0] v, input string text);
		if ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle);
		end
		in_valid <= 1'b1;
		value    <= v;
		do @(posedge clk); while (!in_ready);
		if (text.len() == 0)
			decimal_text(v);
		else
			for (int i = 0; i < text.len(); i++)
				pending_chars.push_back('{CW'(text[i]), i == text.len() - 1});
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_chars.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		char_word_t exp_word;
		out_ready <= ($urandom_range(99) >= recv_idle);
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_chars.size() == 0) begin
					$error("unexpected word: character %0d last %0b", character, last);
					errors++;
				end else begin
					exp_word = pending_chars.pop_front();
					if (character !== exp_word.character) begin
						$error("character: expected %0d, got %0d", exp_word.character, character);
						errors++;
					end
					if (last !== exp_word.last) begin
						$error("last: expected %0b, got %0b", exp_word.last, last);
						errors++;
					end
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stall_cycles <= 0;
			else if (stall_cycles + 1 >= STALL_MAX) begin
				$display("DONE: errors detected");
				$finish;
			end else
				stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		int idle_pct[3][2] = '{'{34, 63}, '{63, 34}, '{0, 0}};
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		value        = '0;
		send_idle    = idle_pct[0][0];
		recv_idle    = idle_pct[0][1];
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (vectors[i])
			send_word(vectors[i].value, vectors[i].text);

		for (int p = 0; p < 3; p++) begin
			// hold off until the block has emptied before changing pace
			if (p != 0)
				drain();
			send_idle = idle_pct[p][0];
			recv_idle = idle_pct[p][1];
			repeat (53)
				send_word(random_value(), "");
		end

		drain();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (pending_chars.size() != 0)
			$error("%0d expected words never arrived", pending_chars.size());
		if (errors == 0 && pending_chars.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/sida_pkg.sv
src/sida_ctrl.sv
src/sida_dp.sv
src/signed_int_to_decimal_ascii_core.sv
src/sida_chk.sv
tb/signed_int_to_decimal_ascii_core_tb.sv
